### hw/rtl/lde_pkg.sv
// Shared constants and codes for the edit distance engine.
package lde_pkg;

    localparam int DEF_MAX_LEN     = 64;
    localparam int DEF_SYMBOL_BITS = 16;

    localparam int SYM_PORT_W  = 16;
    localparam int DIST_W      = 7;
    localparam int STAT_W      = 2;
    localparam int DIST_MAX    = 127;
    localparam int OUT_TDATA_W = 16;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic ACT_REF   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

endpackage

### hw/rtl/lde_ref_mem.sv
// Reference symbol store: one write port, one registered read port.
module lde_ref_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int SW    = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [SW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [SW-1:0] rdata
);

    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lde_row_mem.sv
// DP row cost store: one write port, one registered read port.
module lde_row_mem #(
    parameter int DEPTH = 65,
    parameter int LW    = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [LW-1:0] waddr,
    input  logic [LW-1:0] wdata,
    input  logic          re,
    input  logic [LW-1:0] raddr,
    output logic [LW-1:0] rdata
);

    logic [LW-1:0] mem [DEPTH];
    logic [LW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lde_cell.sv
// One DP cell update: diagonal on match, else one plus the smallest neighbor.
module lde_cell #(
    parameter int CW = 7
) (
    input  logic          match,
    input  logic [CW-1:0] diag,
    input  logic [CW-1:0] above,
    input  logic [CW-1:0] left,
    output logic [CW-1:0] cost
);

    logic [CW-1:0] min_da;
    logic [CW-1:0] min_all;

    always_comb begin
        min_da  = (above < diag) ? above : diag;
        min_all = (left < min_da) ? left : min_da;
        cost    = match ? diag : min_all + CW'(1);
    end

endmodule

### hw/rtl/levenshtein_distance_engine_top.sv
// Top level of the Levenshtein edit distance engine.
//
// Load reference symbols (tuser = 0), the last one marked by tlast, then stream
// query symbols (tuser = 1); the query symbol with tlast set returns one
// transaction with the distance and a status, and the engine clears itself for
// the next pair. A query symbol within MAX_LEN sweeps one DP row through the row
// cost memory, one column per cycle, as the memory has a single read port and a
// single write port. The query symbol marked last then loads its result into
// the output register, waiting only while an earlier result is still held there.
// A result waits in that register and does not block the input; only the next
// result waits for it to be taken. No clearing pass runs after reset: the first
// row of a pair is taken from the column index.
module levenshtein_distance_engine_top
    import lde_pkg::*;
#(
    parameter int MAX_LEN     = DEF_MAX_LEN,
    parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SYM_PORT_W-1:0]  s_tdata,   // [15:0] symbol
    input  logic [0:0]             s_tuser,   // [0] action
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [6:0] distance, [8:7] status
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = (SYMBOL_BITS < SYM_PORT_W) ? SYMBOL_BITS : SYM_PORT_W;
    localparam int XW = (LW > DIST_W) ? LW : DIST_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROW  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [LW-1:0]     ref_len_reg, ref_len_next;
    logic [LW-1:0]     q_count_reg, q_count_next;
    logic              ref_done_reg, ref_done_next;
    logic              ovf_reg, ovf_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [SW-1:0]     sym_reg, sym_next;
    logic              last_reg, last_next;
    logic [LW-1:0]     diag_reg, diag_next;
    logic [LW-1:0]     left_reg, left_next;
    logic [LW-1:0]     col_reg, col_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    logic              ref_we, ref_re;
    logic [AW-1:0]     ref_waddr, ref_raddr;
    logic [SW-1:0]     ref_rdata;
    logic              row_we, row_re;
    logic [LW-1:0]     row_waddr, row_wdata, row_raddr, row_rdata;

    logic [LW-1:0]     above;
    logic [LW-1:0]     cost;
    logic [XW-1:0]     dist_ext;
    logic              s_accept;

    lde_ref_mem #(.DEPTH(MAX_LEN), .AW(AW), .SW(SW)) u_ref_mem (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (s_tdata[SW-1:0]),
        .re    (ref_re),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    lde_row_mem #(.DEPTH(MAX_LEN + 1), .LW(LW)) u_row_mem (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // Before the first row of a pair, an entry holds its column index.
    assign above = (q_count_reg == '0) ? col_reg : row_rdata;

    lde_cell #(.CW(LW)) u_cell (
        .match (ref_rdata == sym_reg),
        .diag  (diag_reg),
        .above (above),
        .left  (left_reg),
        .cost  (cost)
    );

    assign s_accept = s_tvalid && (state_reg == ST_IDLE);
    assign dist_ext = XW'(left_reg);

    always_comb begin
        state_next    = state_reg;
        ref_len_next  = ref_len_reg;
        q_count_next  = q_count_reg;
        ref_done_next = ref_done_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        sym_next      = sym_reg;
        last_next     = last_reg;
        diag_next     = diag_reg;
        left_next     = left_reg;
        col_next      = col_reg;
        dist_next     = dist_reg;
        stat_next     = stat_reg;
        ref_we        = 1'b0;
        ref_waddr     = AW'(ref_len_reg);
        ref_re        = 1'b0;
        ref_raddr     = '0;
        row_we        = 1'b0;
        row_waddr     = '0;
        row_wdata     = '0;
        row_re        = 1'b0;
        row_raddr     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == ACT_REF) begin
                        if (!ref_done_reg) begin
                            if (ref_len_reg < LW'(MAX_LEN)) begin
                                ref_we       = 1'b1;
                                ref_len_next = ref_len_reg + LW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                            if (s_tlast) begin
                                ref_done_next = 1'b1;
                            end
                        end
                    end else begin
                        ref_done_next = 1'b1;
                        last_next     = s_tlast;
                        if (q_count_reg < LW'(MAX_LEN)) begin
                            // Column zero is written now; old value is the diagonal.
                            row_we    = 1'b1;
                            row_waddr = '0;
                            row_wdata = q_count_reg + LW'(1);
                            sym_next  = s_tdata[SW-1:0];
                            diag_next = q_count_reg;
                            left_next = q_count_reg + LW'(1);
                            if (ref_len_reg == '0) begin
                                q_count_next = q_count_reg + LW'(1);
                                state_next   = s_tlast ? ST_DONE : ST_IDLE;
                            end else begin
                                row_re     = 1'b1;
                                row_raddr  = LW'(1);
                                ref_re     = 1'b1;
                                ref_raddr  = '0;
                                col_next   = LW'(1);
                                state_next = ST_ROW;
                            end
                        end else begin
                            ovf_next = 1'b1;
                            if (s_tlast) begin
                                state_next = ST_DONE;
                            end
                        end
                    end
                end
            end
            ST_ROW: begin
                row_we    = 1'b1;
                row_waddr = col_reg;
                row_wdata = cost;
                left_next = cost;
                diag_next = above;
                if (col_reg == ref_len_reg) begin
                    q_count_next = q_count_reg + LW'(1);
                    state_next   = last_reg ? ST_DONE : ST_IDLE;
                end else begin
                    // Fetch the next column while this one is written back.
                    row_re    = 1'b1;
                    row_raddr = col_reg + LW'(1);
                    ref_re    = 1'b1;
                    ref_raddr = AW'(col_reg);
                    col_next  = col_reg + LW'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    if (ref_len_reg == '0) begin
                        dist_next = '0;
                        stat_next = STAT_EMPTY;
                    end else begin
                        dist_next = (dist_ext > XW'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                               : dist_ext[DIST_W-1:0];
                        stat_next = ovf_reg ? STAT_OVERFLOW : STAT_OK;
                    end
                    ref_len_next  = '0;
                    q_count_next  = '0;
                    ref_done_next = 1'b0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ref_len_reg  <= '0;
            q_count_reg  <= '0;
            ref_done_reg <= 1'b0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ref_len_reg  <= ref_len_next;
            q_count_reg  <= q_count_next;
            ref_done_reg <= ref_done_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg  <= sym_next;
        last_reg <= last_next;
        diag_reg <= diag_next;
        left_reg <= left_next;
        col_reg  <= col_next;
        dist_reg <= dist_next;
        stat_reg <= stat_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - DIST_W - STAT_W){1'b0}}, stat_reg, dist_reg};

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_ref_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ref_len_reg <= LW'(MAX_LEN)) && (q_count_reg <= LW'(MAX_LEN)))
        else $error("length counter beyond MAX_LEN");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW) |-> (col_reg != '0) && (col_reg <= ref_len_reg))
        else $error("row sweep column out of range");

    a_row_locks_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW) |-> ref_done_reg && $stable(ref_len_reg))
        else $error("reference changed during a row sweep");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench: edit distance engine against a row-by-row DP predictor.
module testbench;
    import lde_pkg::*;

    localparam int MAX_LEN        = DEF_MAX_LEN;
    localparam int RAND_ITEMS     = 750;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int IDLE_PCT       = 33;

    typedef struct packed {
        logic                  action;
        logic [SYM_PORT_W-1:0] symbol;
        logic                  last;
    } sym_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DIST_W-1:0] distance;
    } pair_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SYM_PORT_W-1:0]  s_tdata  = '0;   // [15:0] symbol
    logic [0:0]             s_tuser  = '0;   // [0] action
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [6:0] distance, [8:7] status

    sym_item_t    symbol_feed[$];
    pair_result_t expected_distances[$];
    int           items_sent   = 0;
    int           mismatches   = 0;
    int           stall_cycles = 0;
    logic         calm;

    // model state of the current pair
    logic [SYM_PORT_W-1:0] ref_syms[MAX_LEN];
    int                    row_cost[MAX_LEN+1];
    int                    ref_len;
    int                    qry_cnt;
    logic                  ref_locked;
    logic                  len_ovf;

    levenshtein_distance_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // no idling on either side for a stretch in the middle of the run
    assign calm = (items_sent >= 300) && (items_sent < 450);

    task automatic clear_pair_state();
        int j;
        for (j = 0; j <= MAX_LEN; j++) row_cost[j] = j;
        ref_len    = 0;
        qry_cnt    = 0;
        ref_locked = 1'b0;
        len_ovf    = 1'b0;
    endtask

    // Advance the DP table by one accepted transaction; queue the distance on a final query.
    task automatic apply_symbol(input sym_item_t it);
        int           j;
        int           diag;
        int           above;
        int           cost;
        pair_result_t res;
        if (it.action == ACT_REF) begin
            if (ref_locked) return;
            if (ref_len < MAX_LEN) begin
                ref_syms[ref_len] = it.symbol;
                ref_len++;
            end else begin
                len_ovf = 1'b1;
            end
            if (it.last) ref_locked = 1'b1;
            return;
        end
        ref_locked = 1'b1;
        if (qry_cnt < MAX_LEN) begin
            diag        = row_cost[0];
            row_cost[0] = qry_cnt + 1;
            for (j = 1; j <= ref_len; j++) begin
                above = row_cost[j];
                if (ref_syms[j-1] == it.symbol) begin
                    cost = diag;
                end else begin
                    cost = diag + 1;
                    if (above + 1 < cost) cost = above + 1;
                    if (row_cost[j-1] + 1 < cost) cost = row_cost[j-1] + 1;
                end
                diag        = above;
                row_cost[j] = cost;
            end
            qry_cnt++;
        end else begin
            len_ovf = 1'b1;
        end
        if (!it.last) return;
        if (ref_len == 0) begin
            res.distance = '0;
            res.status   = STAT_EMPTY;
        end else begin
            res.distance = (row_cost[ref_len] > DIST_MAX) ? DIST_W'(DIST_MAX)
                                                          : DIST_W'(row_cost[ref_len]);
            res.status   = len_ovf ? STAT_OVERFLOW : STAT_OK;
        end
        expected_distances.push_back(res);
        clear_pair_state();
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic push_item(input logic act, input logic [SYM_PORT_W-1:0] sym, input logic last);
        sym_item_t it;
        it.action = act;
        it.symbol = sym;
        it.last   = last;
        symbol_feed.push_back(it);
    endtask

    function automatic logic [SYM_PORT_W-1:0] pick_symbol(input int alphabet);
        if (alphabet == 0) return SYM_PORT_W'($urandom_range(0, 65535));
        return SYM_PORT_W'($urandom_range(0, alphabet - 1));
    endfunction

    // One reference/query pair with random lengths and content; returns the items that count.
    task automatic gen_pair(output int counted);
        int   ref_n;
        int   qry_n;
        int   alphabet;
        int   k;
        int   pick;
        logic early_query;
        pick = $urandom_range(0, 99);
        if (pick < 3)       ref_n = 0;
        else if (pick < 6)  ref_n = $urandom_range(60, MAX_LEN);
        else if (pick < 8)  ref_n = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
        else                ref_n = $urandom_range(1, 8);
        pick = $urandom_range(0, 99);
        if (pick < 5)       qry_n = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
        else if (pick < 10) qry_n = $urandom_range(20, MAX_LEN);
        else                qry_n = $urandom_range(1, 8);
        alphabet    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 4);
        early_query = (ref_n > 0) && ($urandom_range(0, 9) == 0);
        for (k = 0; k < ref_n; k++)
            push_item(ACT_REF, pick_symbol(alphabet), (k == ref_n - 1) && !early_query);
        // stray reference transactions after the lock; the engine drops them
        if (ref_n > 0 && !early_query && $urandom_range(0, 9) == 0) begin
            for (k = 0; k < $urandom_range(1, 2); k++)
                push_item(ACT_REF, pick_symbol(alphabet), 1'($urandom_range(0, 1)));
        end
        for (k = 0; k < qry_n; k++)
            push_item(ACT_QUERY, pick_symbol(alphabet), k == qry_n - 1);
        counted = ref_n + qry_n;
    endtask

    // driver
    always @(posedge aclk) begin
        sym_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (symbol_feed.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = symbol_feed.pop_front();
                s_tvalid   <= 1'b1;
                s_tdata    <= nxt.symbol;
                s_tuser    <= nxt.action;
                s_tlast    <= nxt.last;
                items_sent <= items_sent + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor
    always @(posedge aclk) begin
        pair_result_t want;
        sym_item_t    seen;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_distances.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tdata=%h", m_tdata));
                end else begin
                    want = expected_distances.pop_front();
                    if (m_tdata[DIST_W-1:0] !== want.distance)
                        report_mismatch($sformatf("distance %0d, want %0d",
                                                  m_tdata[DIST_W-1:0], want.distance));
                    if (m_tdata[DIST_W +: STAT_W] !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_tdata[DIST_W +: STAT_W], want.status));
                end
            end
            if (s_tvalid && s_tready) begin
                seen.action = s_tuser[0];
                seen.symbol = s_tdata;
                seen.last   = s_tlast;
                apply_symbol(seen);
            end
        end
    end

    // watchdog: end the run if no transaction moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("levenshtein_distance_engine_top regression: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int counted;
        int n;
        int k;
        clear_pair_state();

        // empty reference
        push_item(ACT_QUERY, 16'h0001, 1'b1);
        // symbol extremes, exact match
        push_item(ACT_REF,   16'h0000, 1'b0);
        push_item(ACT_REF,   16'hFFFF, 1'b1);
        push_item(ACT_QUERY, 16'h0000, 1'b0);
        push_item(ACT_QUERY, 16'hFFFF, 1'b1);
        // single substitution
        push_item(ACT_REF,   16'hFFFF, 1'b1);
        push_item(ACT_QUERY, 16'h0000, 1'b1);
        // reference transactions after the lock are dropped
        push_item(ACT_REF,   16'h0011, 1'b1);
        push_item(ACT_REF,   16'h0022, 1'b0);
        push_item(ACT_REF,   16'h0033, 1'b1);
        push_item(ACT_QUERY, 16'h0022, 1'b1);
        // query arrives before the reference is closed
        push_item(ACT_REF,   16'h0005, 1'b0);
        push_item(ACT_REF,   16'h0006, 1'b0);
        push_item(ACT_QUERY, 16'h0006, 1'b1);
        // query longer than reference
        push_item(ACT_REF,   16'hAAAA, 1'b1);
        push_item(ACT_QUERY, 16'hAAAA, 1'b0);
        push_item(ACT_QUERY, 16'h5555, 1'b0);
        push_item(ACT_QUERY, 16'hAAAA, 1'b1);
        // reference longer than query
        push_item(ACT_REF,   16'h0001, 1'b0);
        push_item(ACT_REF,   16'h0002, 1'b0);
        push_item(ACT_REF,   16'h0003, 1'b1);
        push_item(ACT_QUERY, 16'h0002, 1'b1);

        // full-length pair with nothing in common: largest distance
        for (k = 0; k < MAX_LEN; k++) push_item(ACT_REF, 16'h1234, k == MAX_LEN - 1);
        for (k = 0; k < MAX_LEN; k++) push_item(ACT_QUERY, 16'h4321, k == MAX_LEN - 1);
        counted = 2 * MAX_LEN;
        while (counted < RAND_ITEMS) begin
            gen_pair(n);
            counted += n;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (symbol_feed.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_distances.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("levenshtein_distance_engine_top regression: pass");
        else
            $display("levenshtein_distance_engine_top regression: fail");
        $finish;
    end

endmodule
